@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the address cache.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/arc_pkg.sv @@
// Types and constants of the address resolution cache.
// Depends on nothing; imported by the cache top level.
package arc_pkg;

    localparam int CMD_W    = 2;
    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int SEC_W    = 32;
    localparam int AGE_W    = 16;
    localparam int STATUS_W = 2;

    localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 16'd300;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 2'd0,
        CMD_LOOKUP  = 2'd1,
        CMD_CLEANUP = 2'd2,
        CMD_TICK    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_NONE     = 2'd0,
        STATUS_UPDATED  = 2'd1,
        STATUS_INSERTED = 2'd2,
        STATUS_FULL     = 2'd3
    } t_status;

    // One table entry as it is kept in the entry RAM.
    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [SEC_W-1:0] stamp;
        logic             pinned;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

@@ rtl/core/arc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the entry store of the address cache.
module arc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/address_resolution_cache_with_aging.sv @@
// Top level of the address resolution cache with entry aging.
// Depends on arc_pkg, arc_ram and assert_macros.svh.
//
//   Channel   Direction  Handshake                     Payload
//   request   in         i_in_valid / o_in_ready       cmd, ip, mac, static mark
//   result    out        o_out_valid / i_out_ready     found, mac, add status
//   config    in         i_cfg_we (no wait)            age limit in seconds
//
// Add, lookup and cleanup requests sweep every table slot through the one read
// port of the entry RAM, one slot per cycle, then pass through the wait state
// and the final state before the block is ready again. A tick request goes
// straight to the final state. A stalled result holds the block in its final
// state until the output register frees. Reset is synchronous and clears the
// valid bits, the seconds counter and the age limit (to 300); there is no
// clearing pass, since a slot without its valid bit is never used.
`include "assert_macros.svh"

module address_resolution_cache_with_aging #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request channel.
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [arc_pkg::CMD_W-1:0]      i_cmd,
    input  logic [arc_pkg::IP_W-1:0]       i_ip_address,
    input  logic [arc_pkg::MAC_W-1:0]      i_mac_address,
    input  logic                           i_static_entry,
    // Result channel.
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_found,
    output logic [arc_pkg::MAC_W-1:0]      o_mac_result,
    output logic [arc_pkg::STATUS_W-1:0]   o_add_status,
    // Configuration port.
    input  logic                           i_cfg_we,
    input  logic [arc_pkg::AGE_W-1:0]      i_cfg_wdata
);

    import arc_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } t_state;

    t_state                r_state;
    t_cmd                  r_cmd;
    logic [IP_W-1:0]       r_ip;
    logic [MAC_W-1:0]      r_mac;
    logic                  r_static;

    // Sweep address and the slot whose data the RAM returns this cycle.
    logic [IDX_W-1:0]      r_rd_addr;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [SEC_W-1:0]      r_seconds;
    logic [AGE_W-1:0]      r_age_limit;

    // What the sweep has found so far.
    logic                  r_match;
    logic [IDX_W-1:0]      r_match_idx;
    logic [MAC_W-1:0]      r_match_mac;
    logic                  r_free_ok;
    logic [IDX_W-1:0]      r_free_idx;

    logic                  r_out_valid;
    logic                  r_found;
    logic [MAC_W-1:0]      r_mac_result;
    t_status               r_add_status;

    logic                  accept;
    logic                  out_free;
    logic                  ram_rd_en;
    logic [ENTRY_W-1:0]    ram_rd_data;
    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    t_entry                wr_entry;
    t_entry                rd_entry;
    logic [SEC_W-1:0]      ent_age;
    logic                  ent_fresh;
    logic                  ent_valid;
    logic                  ent_match;
    logic                  ent_hit;
    logic                  ent_expire;
    t_status               add_status;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Entry store. Only an add writes it, and only in the final state after the
    // sweep, so a read and a write of one slot never overlap and no forwarding
    // is needed.
    assign ram_rd_en   = (r_state == ST_SCAN);
    assign ram_wr_en   = (r_state == ST_DONE) && out_free && (r_cmd == CMD_ADD)
                         && (r_match || r_free_ok);
    assign ram_wr_addr = r_match ? r_match_idx : r_free_idx;

    always_comb begin
        wr_entry.ip     = r_ip;
        wr_entry.mac    = r_mac;
        wr_entry.stamp  = r_seconds;
        wr_entry.pinned = r_static;
    end

    arc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Evaluate the slot returned by the RAM. The age wraps modulo 2^32, and a
    // static entry never expires.
    assign rd_entry   = t_entry'(ram_rd_data);
    assign ent_age    = r_seconds - rd_entry.stamp;
    assign ent_fresh  = rd_entry.pinned || (ent_age < SEC_W'(r_age_limit));
    assign ent_valid  = r_valid[r_rd_idx];
    assign ent_match  = ent_valid && (rd_entry.ip == r_ip);
    // An add also matches an entry that has expired but is not yet cleaned up.
    assign ent_hit    = ent_match && ((r_cmd != CMD_LOOKUP) || ent_fresh);
    assign ent_expire = (r_cmd == CMD_CLEANUP) && ent_valid && !ent_fresh;

    always_comb begin
        if (r_match) begin
            add_status = STATUS_UPDATED;
        end else if (r_free_ok) begin
            add_status = STATUS_INSERTED;
        end else begin
            add_status = STATUS_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_vld    <= 1'b0;
            r_valid     <= '0;
            r_seconds   <= '0;
            r_age_limit <= AGE_LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_age_limit <= i_cfg_wdata;
            end

            r_rd_vld <= ram_rd_en;
            r_rd_idx <= r_rd_addr;

            if (r_rd_vld) begin
                if (ent_hit && !r_match) begin
                    r_match     <= 1'b1;
                    r_match_idx <= r_rd_idx;
                    r_match_mac <= rd_entry.mac;
                end
                // Slots arrive in ascending order, so the first free one is the lowest.
                if (!ent_valid && !r_free_ok) begin
                    r_free_ok  <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
                if (ent_expire) begin
                    r_valid[r_rd_idx] <= 1'b0;
                end
            end

            // The output register empties when its result is taken and is
            // refilled in the same cycle by a request that finishes.
            if (out_free) begin
                r_out_valid <= (r_state == ST_DONE);
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd     <= t_cmd'(i_cmd);
                        r_ip      <= i_ip_address;
                        r_mac     <= i_mac_address;
                        r_static  <= i_static_entry;
                        r_match   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_rd_addr <= '0;
                        r_state   <= (t_cmd'(i_cmd) == CMD_TICK) ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_rd_addr == LAST_IDX) begin
                        r_state <= ST_WAIT;
                    end else begin
                        r_rd_addr <= r_rd_addr + 1'b1;
                    end
                end
                ST_WAIT: begin
                    // The last slot is evaluated in this cycle.
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_found      <= (r_cmd == CMD_LOOKUP) && r_match;
                        r_mac_result <= ((r_cmd == CMD_LOOKUP) && r_match) ? r_match_mac
                                                                           : '0;
                        r_add_status <= (r_cmd == CMD_ADD) ? add_status : STATUS_NONE;
                        if (ram_wr_en) begin
                            r_valid[ram_wr_addr] <= 1'b1;
                        end
                        if (r_cmd == CMD_TICK) begin
                            r_seconds <= r_seconds + 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_mac_result = r_mac_result;
    assign o_add_status = r_add_status;

    // No RAM data is in flight while a new request can be taken.
    `ASSERT_ALWAYS(a_no_read_at_ready, i_clk, i_rst_n, !(o_in_ready && r_rd_vld))
    // A full report is only given when every slot holds a valid entry.
    `ASSERT_ALWAYS(a_full_means_all_valid, i_clk, i_rst_n,
        !((r_state == ST_DONE) && (r_cmd == CMD_ADD) && !r_match && !r_free_ok) || (&r_valid))
    // Finishing a request always leaves a result in the output register.
    `ASSERT_NEXT(a_done_gives_result, i_clk, i_rst_n,
        (r_state == ST_DONE) && out_free, o_out_valid && (r_state == ST_IDLE))
    // A result never reports both a lookup hit and an add status.
    `ASSERT_ALWAYS(a_result_kind, i_clk, i_rst_n,
        !(o_out_valid && o_found && (o_add_status != STATUS_NONE)))

endmodule

@@ tb/arc_cache_tracker.sv @@
`timescale 1ns / 100ps
// Mirrors the address cache from its ports: keeps its own copy of the table,
// the seconds counter and the age limit, works out every reply and compares.
// Depends on arc_pkg.
module arc_cache_tracker #(
    parameter int SLOTS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [arc_pkg::CMD_W-1:0]      i_cmd,
    input  logic [arc_pkg::IP_W-1:0]       i_ip_address,
    input  logic [arc_pkg::MAC_W-1:0]      i_mac_address,
    input  logic                           i_static_entry,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_found,
    input  logic [arc_pkg::MAC_W-1:0]      i_mac_result,
    input  logic [arc_pkg::STATUS_W-1:0]   i_add_status,
    input  logic                           i_cfg_we,
    input  logic [arc_pkg::AGE_W-1:0]      i_cfg_wdata,
    output int                             o_pending,
    output int                             o_errors
);
    import arc_pkg::*;

    typedef struct packed {
        logic             found;
        logic [MAC_W-1:0] mac;
        t_status          status;
    } t_reply;

    logic             slot_valid  [SLOTS];
    logic [IP_W-1:0]  slot_ip     [SLOTS];
    logic [MAC_W-1:0] slot_mac    [SLOTS];
    logic [SEC_W-1:0] slot_stamp  [SLOTS];
    logic             slot_static [SLOTS];
    logic [SEC_W-1:0] seconds;
    logic [AGE_W-1:0] age_limit;
    t_reply           replies_due[$];
    int               mismatches = 0;

    task automatic report_mismatch(input string what);
        $display("%0t: reply mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Age is a wrapping difference; static entries never go stale.
    function automatic logic slot_fresh(int k);
        logic [SEC_W-1:0] age;
        age = seconds - slot_stamp[k];
        return slot_static[k] || (age < age_limit);
    endfunction

    function automatic t_reply resolve_request(t_cmd op, logic [IP_W-1:0] ip,
                                               logic [MAC_W-1:0] mac, logic st);
        t_reply r;
        int     k;
        int     hit;
        int     hole;
        r    = '0;
        hit  = -1;
        hole = -1;
        case (op)
            CMD_ADD: begin
                for (k = 0; k < SLOTS; k++) begin
                    if (hit < 0 && slot_valid[k] && slot_ip[k] == ip)
                        hit = k;
                    if (hole < 0 && !slot_valid[k])
                        hole = k;
                end
                if (hit >= 0) begin
                    r.status = STATUS_UPDATED;
                end else if (hole >= 0) begin
                    r.status         = STATUS_INSERTED;
                    hit              = hole;
                    slot_valid[hole] = 1'b1;
                    slot_ip[hole]    = ip;
                end else begin
                    r.status = STATUS_FULL;
                end
                if (hit >= 0) begin
                    slot_mac[hit]    = mac;
                    slot_stamp[hit]  = seconds;
                    slot_static[hit] = st;
                end
            end
            CMD_LOOKUP: begin
                for (k = 0; k < SLOTS; k++) begin
                    if (hit < 0 && slot_valid[k] && slot_ip[k] == ip && slot_fresh(k))
                        hit = k;
                end
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.mac   = slot_mac[hit];
                end
            end
            CMD_CLEANUP: begin
                for (k = 0; k < SLOTS; k++) begin
                    if (slot_valid[k] && !slot_fresh(k))
                        slot_valid[k] = 1'b0;
                end
            end
            default: begin
                seconds = seconds + 1'b1;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                slot_valid[k]  = 1'b0;
                slot_ip[k]     = '0;
                slot_mac[k]    = '0;
                slot_stamp[k]  = '0;
                slot_static[k] = 1'b0;
            end
            seconds   = '0;
            age_limit = AGE_LIMIT_RESET;
            replies_due.delete();
        end else begin
            if (i_cfg_we)
                age_limit = i_cfg_wdata;
            // Replies are taken before new requests so a reply never pairs
            // with a request accepted on the same edge.
            if (i_out_valid && i_out_ready) begin
                got.found  = i_found;
                got.mac    = i_mac_result;
                got.status = t_status'(i_add_status);
                if (replies_due.size() == 0) begin
                    report_mismatch("reply with no request waiting");
                end else begin
                    want = replies_due.pop_front();
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found %0b, wanted %0b",
                                                  got.found, want.found));
                    if (got.mac !== want.mac)
                        report_mismatch($sformatf("mac_result %h, wanted %h",
                                                  got.mac, want.mac));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("add_status %0d, wanted %0d",
                                                  got.status, want.status));
                end
            end
            if (i_in_valid && i_in_ready)
                replies_due.push_back(resolve_request(t_cmd'(i_cmd), i_ip_address,
                                                      i_mac_address, i_static_entry));
        end
        o_pending <= replies_due.size();
        o_errors  <= mismatches;
    end

endmodule

@@ tb/address_resolution_cache_with_aging_tb.sv @@
`timescale 1ns / 100ps
// Stimulus and verdict for the address resolution cache with aging.
// Depends on arc_pkg, the cache top level and arc_cache_tracker.
module address_resolution_cache_with_aging_tb;
    import arc_pkg::*;

    localparam int SLOTS       = 16;
    // The address pool is a little larger than the table, so adds from the
    // pool alone keep the table close to full and regularly overflow it.
    localparam int POOL        = 20;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 160;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    t_cmd               req_cmd;
    logic [IP_W-1:0]    req_ip;
    logic [MAC_W-1:0]   req_mac;
    logic               req_static;
    logic               rsp_valid;
    logic               rsp_ready = 1'b1;
    logic               rsp_found;
    logic [MAC_W-1:0]   rsp_mac;
    logic [STATUS_W-1:0] rsp_status;
    logic               cfg_we;
    logic [AGE_W-1:0]   cfg_wdata;

    int                 pending;
    int                 errors;
    int                 stall_left = 0;
    int                 stall_pct  = 0;
    int                 gap_pct    = 0;
    logic [IP_W-1:0]    ip_pool [POOL];

    always #5 clk = ~clk;

    address_resolution_cache_with_aging #(
        .TABLE_ENTRIES(SLOTS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (req_valid),
        .o_in_ready     (req_ready),
        .i_cmd          (req_cmd),
        .i_ip_address   (req_ip),
        .i_mac_address  (req_mac),
        .i_static_entry (req_static),
        .o_out_valid    (rsp_valid),
        .i_out_ready    (rsp_ready),
        .o_found        (rsp_found),
        .o_mac_result   (rsp_mac),
        .o_add_status   (rsp_status),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata)
    );

    // The tracker watches both channels and the configuration port, predicts
    // each reply and reports how many are still owed and how many were wrong.
    arc_cache_tracker #(
        .SLOTS(SLOTS)
    ) tracker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (req_valid),
        .i_in_ready     (req_ready),
        .i_cmd          (req_cmd),
        .i_ip_address   (req_ip),
        .i_mac_address  (req_mac),
        .i_static_entry (req_static),
        .i_out_valid    (rsp_valid),
        .i_out_ready    (rsp_ready),
        .i_found        (rsp_found),
        .i_mac_result   (rsp_mac),
        .i_add_status   (rsp_status),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .o_pending      (pending),
        .o_errors       (errors)
    );

    // Back-pressure on the result channel. When a stall starts, ready drops
    // and stays low while a randomly drawn stall count runs down; stall_pct sets
    // how often bursts start, and a phase with stall_pct at zero never stalls.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < stall_pct) begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(7);
        end else begin
            rsp_ready <= 1'b1;
        end
    end

    // Presents one request at the current falling edge and holds it until
    // the block takes it. Returns on the falling edge after acceptance with
    // valid still high, so a following request keeps valid up without a dip.
    task automatic send_request(input t_cmd op, input logic [IP_W-1:0] ip,
                                input logic [MAC_W-1:0] mac, input logic st);
        req_cmd    <= op;
        req_ip     <= ip;
        req_mac    <= mac;
        req_static <= st;
        req_valid  <= 1'b1;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    // Lowers valid and waits until every predicted reply has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // The age limit is only changed while the block is idle. Every request
    // yields a reply, so once nothing is owed the block is back to idle.
    task automatic set_age_limit(input logic [AGE_W-1:0] limit);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [MAC_W-1:0] any_mac();
        logic [MAC_W-1:0] m;
        m[47:32] = 16'($urandom);
        m[31:0]  = $urandom;
        return m;
    endfunction

    // One random request. Most of the traffic works on the fixed address
    // pool, so adds, refreshes, expiries and lookups hit the same entries.
    // Stray addresses are only ever added as dynamic entries, so they age
    // out and cannot clog the table for the rest of the run. Fields that a
    // command ignores still carry random values.
    task automatic random_request();
        int               pick;
        logic [IP_W-1:0]  ip;
        pick = $urandom_range(99);
        ip   = ip_pool[$urandom_range(POOL-1)];
        if ($urandom_range(99) < gap_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        if (pick < 35)
            send_request(CMD_ADD, ip, any_mac(), $urandom_range(99) < 25);
        else if (pick < 40)
            send_request(CMD_ADD, $urandom, any_mac(), 1'b0);
        else if (pick < 65)
            send_request(CMD_LOOKUP, ip, any_mac(), 1'($urandom_range(1)));
        else if (pick < 70)
            send_request(CMD_LOOKUP, $urandom, any_mac(), 1'($urandom_range(1)));
        else if (pick < 88)
            send_request(CMD_TICK, $urandom, any_mac(), 1'($urandom_range(1)));
        else
            send_request(CMD_CLEANUP, $urandom, any_mac(), 1'($urandom_range(1)));
    endtask

    initial begin
        logic [AGE_W-1:0] limits [PHASES];

        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_cmd    = CMD_TICK;
        req_ip     = '0;
        req_mac    = '0;
        req_static = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;

        // The pool holds both address extremes plus random addresses.
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int k = 2; k < POOL; k++)
            ip_pool[k] = $urandom;

        // Age limits per random phase: both extremes, the reset value and
        // several short limits that let entries expire within a phase.
        limits = '{16'd3, 16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd5, 16'd300,
                   16'd4, 16'd10, 16'hFFFE, 16'd1, 16'd6};
        limits[8] = 16'($urandom_range(2, 20));

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset age limit. A lookup on the empty
        // table misses; both address extremes go in, one of them static.
        send_request(CMD_LOOKUP, ip_pool[0], '1, 1'b1);
        send_request(CMD_ADD, ip_pool[0], '0, 1'b0);
        send_request(CMD_ADD, ip_pool[1], '1, 1'b1);
        send_request(CMD_LOOKUP, ip_pool[0], '0, 1'b0);
        // Adding a known address rewrites it in place.
        send_request(CMD_ADD, ip_pool[0], any_mac(), 1'b0);
        // Fill every remaining slot, then one more add finds the table full.
        for (int k = 2; k < SLOTS; k++)
            send_request(CMD_ADD, ip_pool[k], any_mac(), 1'b0);
        send_request(CMD_ADD, ip_pool[SLOTS], any_mac(), 1'b0);

        // With a one-second limit a single tick ages out every dynamic entry.
        // An expired entry that is still present misses on lookup but is
        // refreshed in place by an add; cleanup then drops the stale ones.
        set_age_limit(16'd1);
        send_request(CMD_TICK, '0, '0, 1'b0);
        send_request(CMD_LOOKUP, ip_pool[0], '0, 1'b0);
        send_request(CMD_ADD, ip_pool[0], any_mac(), 1'b0);
        send_request(CMD_CLEANUP, '1, '1, 1'b1);
        send_request(CMD_TICK, '1, '1, 1'b1);
        send_request(CMD_CLEANUP, '0, '0, 1'b0);
        // The static entry survives every cleanup; the dynamic one is gone.
        send_request(CMD_LOOKUP, ip_pool[1], '0, 1'b0);
        send_request(CMD_LOOKUP, ip_pool[0], '0, 1'b0);

        // Random phases. Idling on both sides varies from phase to phase,
        // and the last phase runs with no idling at all.
        for (int p = 0; p < PHASES; p++) begin
            set_age_limit(limits[p]);
            if (p == PHASES - 1) begin
                stall_pct = 0;
                gap_pct   = 0;
            end else begin
                stall_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 20 : 50;
                gap_pct   = (p % 4 == 0) ? 0 : (p % 4 == 2) ? 15 : 40;
            end
            repeat (PHASE_ITEMS) random_request();
        end

        // Let the last replies come back, then give a stray reply time to
        // show up before the verdict.
        wait_drained();
        repeat (40) @(negedge clk);
        if (errors == 0)
            $display("PASS address_resolution_cache_with_aging");
        else
            $display("FAIL address_resolution_cache_with_aging");
        $finish;
    end

    // Guard against a hung handshake: a correct run ends far earlier.
    initial begin
        #5_000_000;
        $display("FAIL address_resolution_cache_with_aging");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/arc_pkg.sv
rtl/core/arc_ram.sv
rtl/core/address_resolution_cache_with_aging.sv
tb/arc_cache_tracker.sv
tb/address_resolution_cache_with_aging_tb.sv
